// ----- rtl/core/lcdw_pkg.sv -----
// Shared types and constants of the LCD expander write engine.
package lcdw_pkg;

  localparam int unsigned CmdWidth     = 2;
  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned ColWidth     = 6;
  localparam int unsigned TickWidth    = 16;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [ByteWidth-1:0] CursorRow0  = 8'h80;
  localparam logic [ByteWidth-1:0] CursorRow1  = 8'hC0;
  localparam logic [ByteWidth-1:0] HighNibMask = 8'hF0;

  localparam logic [ByteWidth-1:0] RstDeviceAddress = 8'd78;
  localparam logic [ByteWidth-1:0] RstSelectMask    = 8'd1;
  localparam logic [ByteWidth-1:0] RstEnableMask    = 8'd4;
  localparam logic [ByteWidth-1:0] RstBacklightMask = 8'd8;
  localparam logic [TickWidth-1:0] RstHalfBitTicks  = 16'd5;
  localparam logic [TickWidth-1:0] RstHoldTicks     = 16'd5;
  localparam logic [TickWidth-1:0] RstSettleTicks   = 16'd40;

  typedef enum logic [CmdWidth-1:0] {
    CMD_TICK   = 2'd0,
    CMD_BYTE   = 2'd1,
    CMD_NIBBLE = 2'd2,
    CMD_CURSOR = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_DEVICE_ADDRESS = 3'd0,
    CFG_SELECT_MASK    = 3'd1,
    CFG_ENABLE_MASK    = 3'd2,
    CFG_BACKLIGHT_MASK = 3'd3,
    CFG_HALF_BIT_TICKS = 3'd4,
    CFG_HOLD_TICKS     = 3'd5,
    CFG_SETTLE_TICKS   = 3'd6
  } cfg_idx_e;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_A1     = 5'd1,
    PH_A2     = 5'd2,
    PH_A3     = 5'd3,
    PH_A4     = 5'd4,
    PH_B1     = 5'd5,
    PH_B2     = 5'd6,
    PH_B3     = 5'd7,
    PH_C1     = 5'd8,
    PH_C2     = 5'd9,
    PH_C3     = 5'd10,
    PH_D1     = 5'd11,
    PH_D2     = 5'd12,
    PH_D3     = 5'd13,
    PH_HOLD   = 5'd14,
    PH_SETTLE = 5'd15,
    PH_DONE   = 5'd16
  } phase_e;

  typedef struct packed {
    logic [ByteWidth-1:0] device_address;
    logic [ByteWidth-1:0] select_mask;
    logic [ByteWidth-1:0] enable_mask;
    logic [ByteWidth-1:0] backlight_mask;
    logic [TickWidth-1:0] half_bit_ticks;
    logic [TickWidth-1:0] enable_hold_ticks;
    logic [TickWidth-1:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic busy_res;
    logic rejected;
  } res_t;

endpackage

// ----- rtl/core/lcdw_if.sv -----
// Handshake channels for request words and result words.
interface lcdw_req_if;
  logic                             valid;
  logic                             ready;
  logic [lcdw_pkg::CmdWidth-1:0]    command;
  logic [lcdw_pkg::ByteWidth-1:0]   value;
  logic                             rs_select;
  logic                             row;
  logic [lcdw_pkg::ColWidth-1:0]    col;

  modport source (output valid, command, value, rs_select, row, col, input ready);
  modport sink   (input valid, command, value, rs_select, row, col, output ready);
endinterface

interface lcdw_res_if;
  logic valid;
  logic ready;
  logic scl_level;
  logic sda_level;
  logic busy_res;
  logic rejected;

  modport source (output valid, scl_level, sda_level, busy_res, rejected, input ready);
  modport sink   (input valid, scl_level, sda_level, busy_res, rejected, output ready);
endinterface

// ----- rtl/core/lcdw_cfg_regs.sv -----
// Configuration register file of the LCD expander write engine.
module lcdw_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lcdw_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [lcdw_pkg::CfgDataWidth-1:0]  cfg_wdata_i,
  output lcdw_pkg::cfg_t                     cfg_o
);
  import lcdw_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEVICE_ADDRESS: cfg_d.device_address    = cfg_wdata_i[ByteWidth-1:0];
        CFG_SELECT_MASK:    cfg_d.select_mask       = cfg_wdata_i[ByteWidth-1:0];
        CFG_ENABLE_MASK:    cfg_d.enable_mask       = cfg_wdata_i[ByteWidth-1:0];
        CFG_BACKLIGHT_MASK: cfg_d.backlight_mask    = cfg_wdata_i[ByteWidth-1:0];
        CFG_HALF_BIT_TICKS: cfg_d.half_bit_ticks    = cfg_wdata_i[TickWidth-1:0];
        CFG_HOLD_TICKS:     cfg_d.enable_hold_ticks = cfg_wdata_i[TickWidth-1:0];
        CFG_SETTLE_TICKS:   cfg_d.settle_ticks      = cfg_wdata_i[TickWidth-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address    <= RstDeviceAddress;
      cfg_q.select_mask       <= RstSelectMask;
      cfg_q.enable_mask       <= RstEnableMask;
      cfg_q.backlight_mask    <= RstBacklightMask;
      cfg_q.half_bit_ticks    <= RstHalfBitTicks;
      cfg_q.enable_hold_ticks <= RstHoldTicks;
      cfg_q.settle_ticks      <= RstSettleTicks;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/lcdw_seq.sv -----
// Frame sequencer: phase, bit, frame and wait state with one update per word.
module lcdw_seq #(
  parameter int unsigned WAIT_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  logic [lcdw_pkg::CmdWidth-1:0]     command_i,
  input  logic [lcdw_pkg::ByteWidth-1:0]    value_i,
  input  logic                              rs_select_i,
  input  logic                              row_i,
  input  logic [lcdw_pkg::ColWidth-1:0]     col_i,
  input  lcdw_pkg::cfg_t                    cfg_i,
  output lcdw_pkg::res_t                    res_o
);
  import lcdw_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [3:0]             bit_q, bit_d;
  logic                   byte_q, byte_d;
  logic [1:0]             frame_q, frame_d;
  logic [WAIT_WIDTH-1:0]  wait_q, wait_d;
  logic [ByteWidth-1:0]   value_q, value_d;
  logic                   sel_q, sel_d;
  logic                   nib_only_q, nib_only_d;
  logic                   scl_q, scl_d;
  logic                   sda_q, sda_d;
  logic                   rej;

  logic [WAIT_WIDTH-1:0]  half_w;
  logic [WAIT_WIDTH-1:0]  hold_w;
  logic [WAIT_WIDTH-1:0]  settle_w;
  logic [ByteWidth-1:0]   nibble;
  logic [ByteWidth-1:0]   data_byte;
  logic [ByteWidth-1:0]   frame_byte;
  logic [ByteWidth-1:0]   cursor_addr;
  cmd_e                   cmd;

  assign cmd    = cmd_e'(command_i);
  assign half_w = WAIT_WIDTH'(cfg_i.half_bit_ticks);
  assign hold_w = (cfg_i.enable_hold_ticks == '0) ? '0 :
                  WAIT_WIDTH'(cfg_i.enable_hold_ticks - TickWidth'(1));
  assign settle_w = (cfg_i.settle_ticks == '0) ? '0 :
                    WAIT_WIDTH'(cfg_i.settle_ticks - TickWidth'(1));

  assign cursor_addr = (row_i ? CursorRow1 : CursorRow0) + ByteWidth'(col_i);

  always_comb begin
    nibble = frame_q[1] ? {value_q[3:0], 4'b0000} : (value_q & HighNibMask);
    nibble = nibble | (sel_q ? cfg_i.select_mask : '0);
    if (!frame_q[0]) begin
      data_byte = nibble | cfg_i.enable_mask;
    end else begin
      data_byte = nibble & ~cfg_i.enable_mask;
    end
    data_byte  = data_byte | cfg_i.backlight_mask;
    frame_byte = byte_q ? data_byte : cfg_i.device_address;
  end

  always_comb begin
    phase_d    = phase_q;
    bit_d      = bit_q;
    byte_d     = byte_q;
    frame_d    = frame_q;
    wait_d     = wait_q;
    value_d    = value_q;
    sel_d      = sel_q;
    nib_only_d = nib_only_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    rej        = 1'b0;
    if (step_i) begin
      if (phase_q == PH_IDLE) begin
        if (cmd != CMD_TICK) begin
          if (cmd == CMD_CURSOR) begin
            value_d    = cursor_addr;
            sel_d      = 1'b0;
            nib_only_d = 1'b0;
          end else begin
            value_d    = value_i;
            sel_d      = rs_select_i;
            nib_only_d = (cmd == CMD_NIBBLE);
          end
          frame_d = '0;
          byte_d  = 1'b0;
          bit_d   = '0;
          wait_d  = '0;
          phase_d = PH_A1;
        end
      end else begin
        rej = (cmd != CMD_TICK);
        if (wait_q != '0) begin
          wait_d = wait_q - WAIT_WIDTH'(1);
        end else begin
          unique case (phase_q)
            PH_A1: begin sda_d = 1'b1; wait_d = '0; phase_d = PH_A2; end
            PH_A2: begin scl_d = 1'b1; wait_d = half_w; phase_d = PH_A3; end
            PH_A3: begin sda_d = 1'b0; wait_d = half_w; phase_d = PH_A4; end
            PH_A4: begin
              scl_d = 1'b0; wait_d = '0;
              byte_d = 1'b0; bit_d = '0; phase_d = PH_B1;
            end
            PH_B1: begin
              sda_d = frame_byte[3'd7 - bit_q[2:0]];
              wait_d = half_w; phase_d = PH_B2;
            end
            PH_B2: begin scl_d = 1'b1; wait_d = half_w; phase_d = PH_B3; end
            PH_B3: begin
              scl_d = 1'b0; wait_d = '0;
              bit_d = bit_q + 4'd1;
              phase_d = bit_d[3] ? PH_C1 : PH_B1;
            end
            PH_C1: begin sda_d = 1'b1; wait_d = '0; phase_d = PH_C2; end
            PH_C2: begin scl_d = 1'b1; wait_d = half_w; phase_d = PH_C3; end
            PH_C3: begin
              scl_d = 1'b0; wait_d = '0; bit_d = '0;
              if (!byte_q) begin
                byte_d = 1'b1; phase_d = PH_B1;
              end else begin
                phase_d = PH_D1;
              end
            end
            PH_D1: begin sda_d = 1'b0; wait_d = '0; phase_d = PH_D2; end
            PH_D2: begin scl_d = 1'b1; wait_d = half_w; phase_d = PH_D3; end
            PH_D3: begin
              sda_d = 1'b1; wait_d = half_w;
              phase_d = frame_q[0] ? PH_SETTLE : PH_HOLD;
            end
            PH_HOLD: begin
              wait_d = hold_w; frame_d = frame_q + 2'd1; phase_d = PH_A1;
            end
            PH_SETTLE: begin
              wait_d = settle_w;
              if (frame_q == 2'd1 && !nib_only_q) begin
                frame_d = 2'd2; phase_d = PH_A1;
              end else begin
                phase_d = PH_DONE;
              end
            end
            default: begin
              wait_d = '0; frame_d = '0; byte_d = 1'b0; bit_d = '0;
              phase_d = PH_IDLE;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      bit_q      <= '0;
      byte_q     <= 1'b0;
      frame_q    <= '0;
      wait_q     <= '0;
      value_q    <= '0;
      sel_q      <= 1'b0;
      nib_only_q <= 1'b0;
      scl_q      <= 1'b1;
      sda_q      <= 1'b1;
    end else begin
      phase_q    <= phase_d;
      bit_q      <= bit_d;
      byte_q     <= byte_d;
      frame_q    <= frame_d;
      wait_q     <= wait_d;
      value_q    <= value_d;
      sel_q      <= sel_d;
      nib_only_q <= nib_only_d;
      scl_q      <= scl_d;
      sda_q      <= sda_d;
    end
  end

  assign res_o.scl_level = scl_d;
  assign res_o.sda_level = sda_d;
  assign res_o.busy_res  = (phase_d != PH_IDLE);
  assign res_o.rejected  = rej;

  a_idle_wait_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> wait_q == '0 && frame_q == '0)
    else $error("wait or frame count left over in idle");

  a_idle_lines_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> scl_q && sda_q)
    else $error("bus lines not released in idle");

  a_hold_without_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(wait_q) && $stable(scl_q) && $stable(sda_q))
    else $error("sequencer advanced without a word");

  a_bit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_B1 || phase_q == PH_B2 || phase_q == PH_B3) |-> !bit_q[3])
    else $error("bit position out of range inside a byte");

endmodule

// ----- rtl/core/lcd_i2c_expander_writer_core.sv -----
// Top level of the LCD expander write engine: request channel, sequencer, result register.
// The result word of an accepted request word is registered and offered in the next cycle.
// Throughput: one word per cycle unless stalled; sequencer updates once per accepted word.
// A request stalls only while the result register is full and not being taken.
// Reset: asynchronous, active low; idle phase, bus lines high, config at defaults.
module lcd_i2c_expander_writer_core #(
  parameter int unsigned WAIT_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lcdw_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [lcdw_pkg::CfgDataWidth-1:0]  cfg_wdata_i,
  lcdw_req_if.sink                           item_i,
  lcdw_res_if.source                         result_o
);
  import lcdw_pkg::*;

  cfg_t cfg;
  res_t res_next;
  res_t res_q;
  logic res_valid_q, res_valid_d;
  logic step;

  assign item_i.ready = !res_valid_q || result_o.ready;
  assign step         = item_i.valid && item_i.ready;

  lcdw_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lcdw_seq #(
    .WAIT_WIDTH (WAIT_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .command_i   (item_i.command),
    .value_i     (item_i.value),
    .rs_select_i (item_i.rs_select),
    .row_i       (item_i.row),
    .col_i       (item_i.col),
    .cfg_i       (cfg),
    .res_o       (res_next)
  );

  always_comb begin
    res_valid_d = res_valid_q;
    if (step) begin
      res_valid_d = 1'b1;
    end else if (result_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_next;
    end
  end

  assign result_o.valid     = res_valid_q;
  assign result_o.scl_level = res_q.scl_level;
  assign result_o.sda_level = res_q.sda_level;
  assign result_o.busy_res  = res_q.busy_res;
  assign result_o.rejected  = res_q.rejected;

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> res_valid_q)
    else $error("accepted word left no result");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !result_o.ready |-> !item_i.ready)
    else $error("request taken while result held");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && result_o.ready && !step |=> !res_valid_q)
    else $error("taken result not dropped");

endmodule
